@@ rtl/core/assert_macros.svh @@
// Assertion helper macros used by the table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/core/ksat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksat_pkg
// Types and constants shared by the keyed sensor statistics table.
// ----------------------------------------------------------------------------
package ksat_pkg;
	localparam logic [1:0] CMD_READING = 2'd0;
	localparam logic [1:0] CMD_ADD_ALERT = 2'd1;
	localparam logic [1:0] CMD_RESET_STATS = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_KEY_FULL = 2'd2;

	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_ALERT = 1'b1;

	localparam logic [1:0] CFG_KEY_LIMIT = 2'd0;
	localparam logic [1:0] CFG_SENSOR_LIMIT = 2'd1;
	localparam logic [1:0] CFG_ALERT_LIMIT = 2'd2;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] sensor_ident;
		logic [15:0] key_ident;
		logic signed [31:0] reading;
		logic [15:0] rule_ident;
		logic signed [31:0] rule_low;
		logic signed [31:0] rule_high;
		logic [15:0] requester;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic signed [31:0] stat_last;
		logic signed [31:0] stat_min;
		logic signed [31:0] stat_max;
		logic [15:0] stat_count;
		logic signed [47:0] stat_sum;
		logic [15:0] alert_owner;
		logic [15:0] alert_name;
		logic        last_result;
	} out_item_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic sensor_add;
		logic key_write;
		logic key_new;
		logic key_clear;
		logic rule_add;
		logic out_load;
		logic out_alert;
		logic [1:0] out_status;
		logic out_stats;
		logic out_last;
		logic out_mark;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [1:0] command;
		logic scan_done;
		logic sensor_hit;
		logic sensor_room;
		logic key_hit;
		logic key_room;
		logic rule_dup;
		logic rule_room;
		logic rule_fire;
		logic rule_more;
	} dp_sts_t;
endpackage

@@ rtl/core/ksat_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksat_stream_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface ksat_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/ksat_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksat_datapath
// Tables, scan counter, compares and output register.
// ----------------------------------------------------------------------------
module ksat_datapath import ksat_pkg::*; #(
	parameter int KEY_SLOTS = 16,
	parameter int SENSOR_SLOTS = 16,
	parameter int ALERT_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  dp_cmd_t   cmd,
	input  logic [4:0] key_limit,
	input  logic [4:0] sensor_limit,
	input  logic [4:0] alert_limit,
	output dp_sts_t   sts,
	output out_item_t out_item
);
	localparam int KW = $clog2(KEY_SLOTS + 1);
	localparam int SW = $clog2(SENSOR_SLOTS + 1);
	localparam int AW = $clog2(ALERT_SLOTS + 1);
	localparam int MAXS = (KEY_SLOTS > SENSOR_SLOTS) ?
		((KEY_SLOTS > ALERT_SLOTS) ? KEY_SLOTS : ALERT_SLOTS) :
		((SENSOR_SLOTS > ALERT_SLOTS) ? SENSOR_SLOTS : ALERT_SLOTS);
	localparam int CW = $clog2(MAXS + 1);
	localparam int KI = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int SI = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
	localparam int AI = (ALERT_SLOTS > 1) ? $clog2(ALERT_SLOTS) : 1;

	logic [15:0] sensor_ids_q [SENSOR_SLOTS];
	logic [15:0] key_ids_q [KEY_SLOTS];
	logic signed [31:0] key_last_q [KEY_SLOTS];
	logic signed [31:0] key_min_q [KEY_SLOTS];
	logic signed [31:0] key_max_q [KEY_SLOTS];
	logic [15:0] key_count_q [KEY_SLOTS];
	logic signed [47:0] key_sum_q [KEY_SLOTS];
	logic [15:0] rule_name_q [ALERT_SLOTS];
	logic [15:0] rule_key_q [ALERT_SLOTS];
	logic signed [31:0] rule_low_q [ALERT_SLOTS];
	logic signed [31:0] rule_high_q [ALERT_SLOTS];
	logic [15:0] rule_owner_q [ALERT_SLOTS];

	logic [KW-1:0] keys_q;
	logic [SW-1:0] sensors_q;
	logic [AW-1:0] rules_q;
	in_item_t item_q;
	logic [CW-1:0] idx_q;
	logic sensor_hit_q, key_hit_q, rule_dup_q;
	logic [KI-1:0] slot_q;
	out_item_t out_q;
	out_item_t out_d;

	logic [KW-1:0] klim;
	logic [SW-1:0] slim;
	logic [AW-1:0] alim;
	logic [KI-1:0] ki;
	logic [SI-1:0] si;
	logic [AI-1:0] ai;
	logic s_match, k_match, r_dup, r_fire;
	logic [KI-1:0] wslot;

	always_comb begin
		klim = (32'(key_limit) < KEY_SLOTS) ? KW'(key_limit) : KW'(KEY_SLOTS);
		slim = (32'(sensor_limit) < SENSOR_SLOTS) ? SW'(sensor_limit) : SW'(SENSOR_SLOTS);
		alim = (32'(alert_limit) < ALERT_SLOTS) ? AW'(alert_limit) : AW'(ALERT_SLOTS);
		ki = KI'(idx_q);
		si = SI'(idx_q);
		ai = AI'(idx_q);
		s_match = (32'(idx_q) < 32'(sensors_q)) && (sensor_ids_q[si] == item_q.sensor_ident);
		k_match = (32'(idx_q) < 32'(keys_q)) && (key_ids_q[ki] == item_q.key_ident);
		r_dup = (32'(idx_q) < 32'(rules_q)) && (rule_name_q[ai] == item_q.rule_ident);
		r_fire = (32'(idx_q) < 32'(rules_q)) && (rule_key_q[ai] == item_q.key_ident) &&
			((item_q.reading < rule_low_q[ai]) || (item_q.reading > rule_high_q[ai]));
		wslot = cmd.key_new ? KI'(keys_q) : slot_q;
	end

	always_comb begin
		sts.command = item_q.command;
		sts.scan_done = (32'(idx_q) >= MAXS - 1);
		sts.sensor_hit = sensor_hit_q;
		sts.sensor_room = (sensors_q < slim);
		sts.key_hit = key_hit_q;
		sts.key_room = (keys_q < klim);
		sts.rule_dup = rule_dup_q;
		sts.rule_room = (rules_q < alim);
		sts.rule_fire = r_fire;
		sts.rule_more = (32'(idx_q) + 1 < 32'(rules_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
			sensors_q <= '0;
			rules_q <= '0;
			idx_q <= '0;
			sensor_hit_q <= 1'b0;
			key_hit_q <= 1'b0;
			rule_dup_q <= 1'b0;
		end else begin
			if (cmd.load) item_q <= in_item;
			if (cmd.scan_clr) begin
				idx_q <= '0;
				sensor_hit_q <= 1'b0;
				key_hit_q <= 1'b0;
				rule_dup_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (s_match) sensor_hit_q <= 1'b1;
				if (r_dup) rule_dup_q <= 1'b1;
				if (k_match && !key_hit_q) begin
					key_hit_q <= 1'b1;
					slot_q <= ki;
				end
			end
			if (cmd.sensor_add) begin
				sensor_ids_q[SI'(sensors_q)] <= item_q.sensor_ident;
				sensors_q <= sensors_q + 1'b1;
			end
			if (cmd.key_write) begin
				key_last_q[wslot] <= item_q.reading;
				if (cmd.key_new) begin
					key_ids_q[wslot] <= item_q.key_ident;
					key_min_q[wslot] <= item_q.reading;
					key_max_q[wslot] <= item_q.reading;
					key_count_q[wslot] <= 16'd1;
					key_sum_q[wslot] <= 48'(item_q.reading);
					keys_q <= keys_q + 1'b1;
					slot_q <= wslot;
				end else begin
					if (item_q.reading < key_min_q[wslot]) key_min_q[wslot] <= item_q.reading;
					if (item_q.reading > key_max_q[wslot]) key_max_q[wslot] <= item_q.reading;
					if (key_count_q[wslot] != COUNT_MAX) begin
						key_count_q[wslot] <= key_count_q[wslot] + 16'd1;
						key_sum_q[wslot] <= key_sum_q[wslot] + 48'(item_q.reading);
					end
				end
			end
			if (cmd.key_clear) keys_q <= '0;
			if (cmd.rule_add) begin
				rule_name_q[AI'(rules_q)] <= item_q.rule_ident;
				rule_key_q[AI'(rules_q)] <= item_q.key_ident;
				rule_low_q[AI'(rules_q)] <= item_q.rule_low;
				rule_high_q[AI'(rules_q)] <= item_q.rule_high;
				rule_owner_q[AI'(rules_q)] <= item_q.requester;
				rules_q <= rules_q + 1'b1;
			end
		end
	end

	always_comb begin
		out_d = out_q;
		if (cmd.out_load) begin
			out_d = '0;
			out_d.kind = cmd.out_alert ? KIND_ALERT : KIND_REPLY;
			out_d.status = cmd.out_status;
			out_d.last_result = cmd.out_last;
			if (cmd.out_stats) begin
				out_d.stat_last = key_last_q[slot_q];
				out_d.stat_min = key_min_q[slot_q];
				out_d.stat_max = key_max_q[slot_q];
				out_d.stat_count = key_count_q[slot_q];
				out_d.stat_sum = key_sum_q[slot_q];
			end
			if (cmd.out_alert) begin
				out_d.alert_owner = rule_owner_q[ai];
				out_d.alert_name = rule_name_q[ai];
			end
		end
		if (cmd.out_mark) out_d.last_result = 1'b1;
	end

	always_ff @(posedge clk) begin
		out_q <= out_d;
	end

	assign out_item = out_q;
endmodule

@@ rtl/core/ksat_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksat_ctrl
// Sequencer: accept, table scan, update, reply and alert scan.
// ----------------------------------------------------------------------------
module ksat_ctrl import ksat_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_DEC   = 7'b0000100,
		S_UPD   = 7'b0001000,
		S_SEND  = 7'b0010000,
		S_ALERT = 7'b0100000,
		S_WAIT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic valid_q, valid_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = valid_q;

	always_comb begin
		state_d = state_q;
		valid_d = valid_q && !out_ready;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_DEC;
			end
			S_DEC: begin
				if (!valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					valid_d = 1'b1;
					state_d = S_IDLE;
					case (sts.command)
						CMD_READING: begin
							if (!sts.sensor_hit && !sts.sensor_room) begin
								cmd.out_status = ST_REJECT;
							end else begin
								cmd.sensor_add = !sts.sensor_hit;
								if (sts.key_hit || sts.key_room) begin
									cmd.out_load = 1'b0;
									valid_d = valid_q && !out_ready;
									cmd.key_write = 1'b1;
									cmd.key_new = !sts.key_hit;
									state_d = S_UPD;
								end else begin
									cmd.out_status = ST_KEY_FULL;
								end
							end
						end
						CMD_ADD_ALERT: begin
							if (sts.rule_dup || !sts.rule_room) cmd.out_status = ST_REJECT;
							else cmd.rule_add = 1'b1;
						end
						CMD_RESET_STATS: cmd.key_clear = 1'b1;
						default: cmd.out_status = ST_REJECT;
					endcase
				end
			end
			S_UPD: begin
				if (!valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.out_stats = 1'b1;
					cmd.out_status = ST_OK;
					cmd.scan_clr = 1'b1;
					state_d = S_ALERT;
				end
			end
			S_ALERT: begin
				// The loaded result is offered once it is known whether another one follows.
				if (sts.rule_fire) begin
					valid_d = 1'b1;
					state_d = S_WAIT;
				end else if (sts.rule_more) begin
					cmd.scan_step = 1'b1;
				end else begin
					cmd.out_mark = 1'b1;
					valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WAIT: begin
				if (out_ready) begin
					cmd.out_load = 1'b1;
					cmd.out_alert = 1'b1;
					cmd.out_stats = 1'b1;
					cmd.out_status = ST_OK;
					cmd.scan_step = 1'b1;
					state_d = S_ALERT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
		end
	end
endmodule

@@ rtl/core/keyed_sensor_stats_alert_table_core.sv @@
`timescale 1ns / 1ps
// Sequence: after the accept cycle an item scans every slot of the largest table
// and then decides; a reading that updates a key adds an update step, then checks
// each alert rule in turn and offers each triggered alert before its last result.
// One item at a time: a new item is accepted only when idle; output stalls hold it.
// Reset: arst_n clears the in-use counts, the limits go to 16, table contents stay.
// ----------------------------------------------------------------------------
// keyed_sensor_stats_alert_table_core
// Keyed sensor statistics table with range alerts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module keyed_sensor_stats_alert_table_core import ksat_pkg::*; #(
	parameter int KEY_SLOTS = 16,
	parameter int SENSOR_SLOTS = 16,
	parameter int ALERT_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	ksat_stream_if.sink   in_ch,
	ksat_stream_if.source out_ch
);
	logic [4:0] key_limit_q, sensor_limit_q, alert_limit_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	out_item_t out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_limit_q <= 5'd16;
			sensor_limit_q <= 5'd16;
			alert_limit_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LIMIT: key_limit_q <= cfg_data;
				CFG_SENSOR_LIMIT: sensor_limit_q <= cfg_data;
				CFG_ALERT_LIMIT: alert_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ksat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	ksat_datapath #(
		.KEY_SLOTS(KEY_SLOTS), .SENSOR_SLOTS(SENSOR_SLOTS), .ALERT_SLOTS(ALERT_SLOTS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_ch.data), .cmd(cmd),
		.key_limit(key_limit_q), .sensor_limit(sensor_limit_q),
		.alert_limit(alert_limit_q), .sts(sts), .out_item(out_item)
	);

	assign out_ch.data = out_item;

	`ASSERT_IMPL(a_ready_idle_only, clk, arst_n, in_ch.ready, !cmd.out_load && !cmd.key_write, "busy while ready")
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped while stalled")
	`ASSERT_IMPL(a_no_double_load, clk, arst_n, cmd.out_load && out_ch.valid, out_ch.ready, "result overwritten")
endmodule
